// ----- rtl/ctli_pkg.sv -----
// Shared constants, types and codes for the curve table interpolation block.
`timescale 1ns / 1ps
`default_nettype none

package ctli_pkg;

  // Curve geometry: points on each side of zero climb, in half-metre steps.
  localparam int HALF_POINTS = 20;
  localparam int CURVE_DEPTH = 2 * HALF_POINTS + 1;
  localparam int LAST_SEG    = CURVE_DEPTH - 2;
  localparam int IDX_W       = $clog2(CURVE_DEPTH);

  // Segment index before clamping: -256 + HALF_POINTS .. 255 + HALF_POINTS.
  localparam int SEG_W = 10;
  localparam logic signed [SEG_W-1:0] SEG_LAST = SEG_W'(LAST_SEG);

  localparam int TENTH_W = 4;
  localparam logic [TENTH_W-1:0] TENTHS_FULL = 4'd10;

  // floor(a / 10) == (a * RECIP_TEN) >> RECIP_SHIFT for every a below 2**22
  localparam logic [19:0] RECIP_TEN   = 20'd838861;
  localparam int          RECIP_SHIFT = 23;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_WRITE  = 1'b1
  } ctli_cmd_t;

  // Classified request handed from the front to the back end
  typedef struct packed {
    logic               is_write;
    logic [IDX_W-1:0]   addr;
    logic [TENTH_W-1:0] tenths;
    logic [15:0]        wdata;
  } ctli_req_t;

endpackage

`default_nettype wire

// ----- rtl/ctli_front.sv -----
// Front end: takes requests, works out segment and tenths, buffers them in a short queue.
`timescale 1ns / 1ps
`default_nettype none

module ctli_front
  import ctli_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               in_cmd,
  input  wire logic signed [15:0] in_vario_speed,
  input  wire logic [5:0]         in_entry_index,
  input  wire logic [15:0]        in_entry_value,
  output logic                    req_valid,
  input  wire logic               req_ready,
  output ctli_req_t               req
);

  logic signed [SEG_W-1:0] seg;
  logic [10:0]             tenth_sum;
  ctli_req_t               cls;
  logic                    keep;

  ctli_req_t  q_mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  // floor of speed/128 is the arithmetic shift of the upper nine bits
  always_comb begin
    seg        = {in_vario_speed[15], in_vario_speed[15:7]} + SEG_W'(HALF_POINTS);
    tenth_sum  = 11'(in_vario_speed[6:0]) * 11'd10 + 11'd64;
    cls.is_write = (in_cmd == CMD_WRITE);
    cls.wdata    = in_entry_value;
    cls.tenths   = tenth_sum[10:7];
    cls.addr     = '0;
    keep         = 1'b1;
    if (cls.is_write) begin
      cls.addr = IDX_W'(in_entry_index);
      keep     = (int'(in_entry_index) < CURVE_DEPTH);
    end else if (seg > SEG_LAST) begin
      cls.addr   = IDX_W'(LAST_SEG);
      cls.tenths = TENTHS_FULL;
    end else if (seg[SEG_W-1]) begin
      cls.addr   = '0;
      cls.tenths = '0;
    end else begin
      cls.addr = IDX_W'(seg);
    end
  end

  // writes beyond the table are accepted and dropped here
  assign full      = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_mem[rd_ptr_r];
  assign wr_en     = push && !full && keep;
  assign rd_en     = req_valid && req_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) wr_ptr_r <= !wr_ptr_r;
      if (rd_en) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_mem[wr_ptr_r] <= cls;
  end

endmodule

`default_nettype wire

// ----- rtl/ctli_back.sv -----
// Back end: curve memory, interpolation pipeline and result queue.
`timescale 1ns / 1ps
`default_nettype none

module ctli_back
  import ctli_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire ctli_req_t   req,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_interp_value
);

  logic [15:0] curve_mem [CURVE_DEPTH];

  logic             en, take;
  logic [IDX_W-1:0] rd_addr, rd_addr_nx;

  // stage 1: table read
  logic               rd_vld_r;
  logic [15:0]        start_r, next_r;
  logic [TENTH_W-1:0] tenths_r;
  // stage 2: products
  logic                    mul_vld_r;
  logic signed [19:0]      base_r, base_nxt;
  logic signed [20:0]      step_r, step_nxt;
  logic signed [16:0]      diff;
  // stage 3: sum and magnitude
  logic                    sum_vld_r;
  logic signed [21:0]      num;
  logic                    sum_neg_r;
  logic [19:0]             mag_r, mag_nxt;
  // stage 4: reciprocal multiply
  logic                    div_vld_r;
  logic                    div_neg_r;
  logic [39:0]             quot_prod_r;
  logic [15:0]             quot, res;

  // result queue
  logic [15:0] oq_mem [2];
  logic        oq_wr_ptr_r, oq_rd_ptr_r;
  logic [1:0]  oq_cnt_r, oq_cnt_nxt;
  logic        oq_full, oq_push, oq_pop;

  assign oq_full   = (oq_cnt_r == 2'd2);
  assign en        = !oq_full;
  assign req_ready = en;
  assign take      = req_valid && en;

  assign rd_addr    = req.is_write ? '0 : req.addr;
  assign rd_addr_nx = rd_addr + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (take && req.is_write) curve_mem[req.addr] <= req.wdata;
    if (en) begin
      start_r  <= curve_mem[rd_addr];
      next_r   <= curve_mem[rd_addr_nx];
      tenths_r <= req.tenths;
    end
  end

  always_comb begin
    diff     = 17'(signed'(next_r)) - 17'(signed'(start_r));
    base_nxt = 20'(signed'(start_r)) * 20'sd10;
    step_nxt = 21'(diff) * 21'(signed'({1'b0, tenths_r}));
    num      = 22'(base_r) + 22'(step_r);
    mag_nxt  = num[21] ? 20'(-num) : 20'(num);
    quot     = quot_prod_r[RECIP_SHIFT+15:RECIP_SHIFT];
    res      = div_neg_r ? (16'd0 - quot) : quot;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r      <= base_nxt;
      step_r      <= step_nxt;
      sum_neg_r   <= num[21];
      mag_r       <= mag_nxt;
      div_neg_r   <= sum_neg_r;
      quot_prod_r <= 40'(mag_r) * 40'(RECIP_TEN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      sum_vld_r <= 1'b0;
      div_vld_r <= 1'b0;
    end else if (en) begin
      rd_vld_r  <= take && !req.is_write;
      mul_vld_r <= rd_vld_r;
      sum_vld_r <= mul_vld_r;
      div_vld_r <= sum_vld_r;
    end
  end

  // result queue; the pipeline holds while it is full
  assign oq_push          = div_vld_r && en;
  assign empty            = (oq_cnt_r == 2'd0);
  assign oq_pop           = pop && !empty;
  assign out_interp_value = oq_mem[oq_rd_ptr_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    case ({oq_push, oq_pop})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 2'd1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 2'd1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_cnt_r    <= 2'd0;
      oq_wr_ptr_r <= 1'b0;
      oq_rd_ptr_r <= 1'b0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) oq_wr_ptr_r <= !oq_wr_ptr_r;
      if (oq_pop)  oq_rd_ptr_r <= !oq_rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_mem[oq_wr_ptr_r] <= res;
  end

endmodule

`default_nettype wire

// ----- rtl/curve_table_linear_interpolation_core.sv -----
// Top level of the curve table linear interpolation block.
//
// Input side is a queue: drive a request and raise push; it is taken on a
// clock edge where full is low. in_cmd selects a table write (entry_index,
// entry_value) or a lookup (vario_speed, signed 1/256 m/s).
// Writes give no result; writes with an index past the table are dropped.
// Lookups give one 16-bit interpolated value, in request order.
// Result side is a queue as well: while empty is low the oldest result sits
// on out_interp_value and is taken on an edge where pop is high.
// Throughput: one request per cycle while the result queue has room, set by
// the two-port curve memory read in the first of four pipeline stages.
// When the receiver stalls, the two-entry result queue fills, the pipeline
// holds, then the two-entry request queue fills and full rises.
// Reset (synchronous, active low) empties both queues and the pipeline;
// the curve memory keeps no reset value and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module curve_table_linear_interpolation_core
  import ctli_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               in_cmd,
  input  wire logic signed [15:0] in_vario_speed,
  input  wire logic [5:0]         in_entry_index,
  input  wire logic [15:0]        in_entry_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic [15:0]             out_interp_value
);

  logic      req_valid, req_ready;
  ctli_req_t req;

  ctli_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_cmd         (in_cmd),
    .in_vario_speed (in_vario_speed),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req)
  );

  ctli_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .req              (req),
    .empty            (empty),
    .pop              (pop),
    .out_interp_value (out_interp_value)
  );

endmodule

`default_nettype wire

// ----- rtl/ctli_checker.sv -----
// Port-level checks for the curve table interpolation block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ctli_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] out_interp_value
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("request queue full after reset");

  // pipeline depth: a result only comes out once a lookup has passed every pipeline stage after reset
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> empty ##1 empty ##1 empty ##1 empty ##1 empty)
    else $error("result appeared too early after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_interp_value))
    else $error("stalled result changed");

endmodule

bind curve_table_linear_interpolation_core ctli_checker u_ctli_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_interp_value (out_interp_value)
);

`default_nettype wire

// ----- bench/curve_table_linear_interpolation_core_tb.sv -----
// Self-checking testbench for the curve table linear interpolation core.
`timescale 1ns / 1ps

module curve_table_linear_interpolation_core_tb;
  import ctli_pkg::*;

  localparam int MAX_IDLE        = 14;
  localparam int TARGET_REQUESTS = 400;
  localparam int HOLD_OFF_AT     = 30;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_REPORTS     = 10;

  // Mirror of the curve plus the queue of lookup values still owed by the block
  class curve_scoreboard;
    logic [15:0] curve_words [CURVE_DEPTH];
    bit          written [CURVE_DEPTH];
    logic [15:0] pending_values [$];
    int          errors;

    function new();
      errors = 0;
      foreach (written[i]) begin
        written[i] = 1'b0;
        curve_words[i] = '0;
      end
    endfunction

    // Segment and rounded tenths for a climb rate, clamped at both ends
    function void locate(logic signed [15:0] speed, output int idx, output int tenths);
      int biased;
      int seg;
      biased = int'(speed) + 32768;  // nonnegative, multiple of 128 offset
      seg = biased / 128 - 256 + HALF_POINTS;
      tenths = ((biased % 128) * 10 + 64) / 128;
      if (seg > LAST_SEG) begin
        idx = LAST_SEG;
        tenths = int'(TENTHS_FULL);
      end else if (seg < 0) begin
        idx = 0;
        tenths = 0;
      end else begin
        idx = seg;
      end
    endfunction

    // First curve point a lookup would read that was never written; CURVE_DEPTH if none
    function int missing_entry(logic signed [15:0] speed);
      int idx;
      int tenths;
      locate(speed, idx, tenths);
      if (!written[idx]) return idx;
      if (!written[idx + 1]) return idx + 1;
      return CURVE_DEPTH;
    endfunction

    function logic [15:0] predict_value(logic signed [15:0] speed);
      int idx;
      int tenths;
      int lo;
      int hi;
      int sum;
      locate(speed, idx, tenths);
      lo = int'($signed(curve_words[idx]));
      hi = int'($signed(curve_words[idx + 1]));
      sum = lo * int'(TENTHS_FULL) + (hi - lo) * tenths;
      return 16'(sum / int'(TENTHS_FULL));  // truncates toward zero
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function void note_request(ctli_cmd_t cmd, logic signed [15:0] speed,
                               logic [5:0] idx, logic [15:0] value);
      if (cmd == CMD_WRITE) begin
        if (idx < CURVE_DEPTH) begin
          curve_words[idx] = value;
          written[idx] = 1'b1;
        end
      end else begin
        pending_values.push_back(predict_value(speed));
      end
    endfunction

    function void check_value(logic [15:0] got);
      logic [15:0] want;
      if (pending_values.size() == 0) begin
        report($sformatf("result %h with no pending lookup", got));
      end else begin
        want = pending_values.pop_front();
        if (got !== want)
          report($sformatf("interp_value mismatch: expected %h, got %h", want, got));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  logic               in_cmd;
  logic signed [15:0] in_vario_speed;
  logic [5:0]         in_entry_index;
  logic [15:0]        in_entry_value;
  logic               empty;
  logic               pop;
  logic [15:0]        out_interp_value;

  curve_scoreboard board;
  bit              send_burst;
  bit              drain_burst;
  bit              holding_off;

  curve_table_linear_interpolation_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_cmd           (in_cmd),
    .in_vario_speed   (in_vario_speed),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .empty            (empty),
    .pop              (pop),
    .out_interp_value (out_interp_value)
  );

  always #5 clk = ~clk;

  // Offer one request, after a random idle gap unless bursting or holding off, and wait until it is taken
  task automatic send_request(ctli_cmd_t cmd, logic signed [15:0] speed,
                              logic [5:0] idx, logic [15:0] value);
    int gap;
    gap = (send_burst || holding_off) ? 0 : $urandom_range(MAX_IDLE, 0);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push           <= 1'b1;
    in_cmd         <= cmd;
    in_vario_speed <= speed;
    in_entry_index <= idx;
    in_entry_value <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_request(cmd, speed, idx, value);
  endtask

  task automatic send_write(logic [5:0] idx, logic [15:0] value);
    send_request(CMD_WRITE, 16'($urandom), idx, value);
  endtask

  task automatic send_lookup(logic signed [15:0] speed);
    send_request(CMD_LOOKUP, speed, 6'($urandom), 16'($urandom));
  endtask

  task automatic run_random();
    int                 sent;
    int                 tries;
    int                 span;
    int                 gap_entry;
    logic signed [15:0] speed;
    logic [5:0]         idx;
    sent = 0;
    span = (HALF_POINTS + 1) * 128 + 200;  // a little past both clamps
    while (sent < TARGET_REQUESTS) begin
      if ($urandom_range(24, 0) == 0) send_burst = !send_burst;
      if ($urandom_range(9, 0) < 3) begin
        idx = ($urandom_range(7, 0) == 0) ? 6'($urandom_range(63, 0))
                                          : 6'($urandom_range(CURVE_DEPTH - 1, 0));
        send_write(idx, 16'($urandom));
        if (idx < CURVE_DEPTH) sent++;
      end else begin
        // never read a point that was not loaded yet; load it instead
        tries = 0;
        do begin
          if ($urandom_range(4, 0) == 0) speed = 16'($urandom);
          else speed = 16'(int'($urandom_range(2 * span, 0)) - span);
          tries++;
          gap_entry = board.missing_entry(speed);
        end while (gap_entry < CURVE_DEPTH && tries < 8);
        if (gap_entry < CURVE_DEPTH) send_write(6'(gap_entry), 16'($urandom));
        else send_lookup(speed);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    push           = 1'b0;
    in_cmd         = CMD_LOOKUP;
    in_vario_speed = '0;
    in_entry_index = '0;
    in_entry_value = '0;
    send_burst     = 1'b0;
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes at both ends of the curve and around zero climb
    send_write(6'd0, 16'h8000);
    send_write(6'd1, 16'h7fff);
    send_write(6'd19, 16'h0000);
    send_write(6'd20, 16'h1234);
    send_write(6'd21, 16'hffff);
    send_write(6'd39, 16'h7fff);
    send_write(6'd40, 16'h8000);
    send_write(6'd41, 16'h5555);   // past the table, dropped
    send_write(6'd63, 16'haaaa);   // past the table, dropped
    send_lookup(16'sh8000);        // far below the curve
    send_lookup(16'sh7fff);        // far above the curve
    send_lookup(16'sd0);           // exactly on the middle point
    send_lookup(-16'sd2560);       // first point, zero fraction
    send_lookup(-16'sd2433);       // fraction rounds up to a full ten tenths
    send_lookup(-16'sd2528);       // half tenth rounds up, negative sum truncates
    send_lookup(-16'sd2561);       // one step below the curve
    send_lookup(16'sd2432);        // last segment, zero fraction
    send_lookup(16'sd2532);
    send_lookup(16'sd2560);        // one step above the curve
    send_lookup(-16'sd78);
    send_lookup(16'sd90);
    send_write(6'd20, 16'hedcb);   // overwrite, then read it back at once
    send_lookup(16'sd90);

    run_random();
    @(negedge clk);
    push <= 1'b0;

    while (board.pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_drain
    int stall;
    int taken;
    pop         = 1'b0;
    drain_burst = 1'b0;
    holding_off = 1'b0;
    taken       = 0;
    wait (rst_n === 1'b1);
    forever begin
      // one long hold-off so results back up and full rises
      if (taken == HOLD_OFF_AT) begin
        holding_off = 1'b1;
        @(negedge clk);
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        holding_off = 1'b0;
      end
      stall = drain_burst ? 0 : $urandom_range(MAX_IDLE, 0);
      if (stall > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      board.check_value(out_interp_value);
      taken++;
      if ($urandom_range(24, 0) == 0) drain_burst = !drain_burst;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
